### design/sd3m_pkg.sv
// ============================================================================
// sd3m_pkg - shared types and constants for the three-mode signed divider
// Holds the command and result transaction types, the mode codes and the
// record that travels down the divider pipeline.
// ============================================================================
package sd3m_pkg;

    // Operand width and number of quotient-bit stages.
    localparam int DATA_W    = 64;
    localparam int DIV_STEPS = DATA_W;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY = DIV_STEPS + 2;

    // Width mode codes carried in the opcode field.
    localparam logic [1:0] MODE_32_32     = 2'd0;
    localparam logic [1:0] MODE_64_32     = 2'd1;
    localparam logic [1:0] MODE_64_64     = 2'd2;
    localparam logic [1:0] MODE_64_32_ALT = 2'd3;

    // Fixed quotients for a zero divisor in 32/32 mode.
    localparam logic [DATA_W-1:0] ZERO32_Q_NEG = 64'hFFFF_FFFF_0000_0001;
    localparam logic [DATA_W-1:0] ZERO32_Q_POS = 64'h0000_0000_FFFF_FFFF;

    // Fixed quotient for the most negative word over minus one in 32/32 mode.
    localparam logic [DATA_W-1:0] OVF32_Q      = 64'h0000_0000_8000_0000;

    // Command transaction.
    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] numerator;
        logic signed [DATA_W-1:0] denominator;
    } cmd_t;

    // Result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] quotient;
        logic signed [DATA_W-1:0] remainder;
        logic                     divide_by_zero;
    } result_t;

    // Sign and special-case control that rides along with each item.
    typedef struct packed {
        logic valid;
        logic q_neg;
        logic r_neg;
        logic zero32;
        logic ovf32;
        logic dz;
    } ctrl_t;

    // Magnitude datapath of one pipeline slot.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] den;
    } work_t;

endpackage

### design/sd3m_prep.sv
// ============================================================================
// sd3m_prep - operand preparation stage
// Selects the operand widths for the mode, takes magnitudes and registers
// them together with the sign and special-case flags.
// ============================================================================
module sd3m_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  sd3m_pkg::cmd_t    cmd,
    output sd3m_pkg::ctrl_t   ctrl_out,
    output sd3m_pkg::work_t   work_out
);
    import sd3m_pkg::*;

    logic [DATA_W-1:0] n_eff;
    logic [DATA_W-1:0] d_eff;
    logic              n_neg;
    logic              d_neg;
    logic              zero32;
    logic              ovf32;
    ctrl_t             ctrl_reg;
    ctrl_t             ctrl_next;
    work_t             work_reg;
    work_t             work_next;

    // Pick the effective operands for the width mode.
    always_comb
    begin
        unique case (cmd.opcode)
            MODE_32_32:
            begin
                n_eff  = {{(DATA_W-32){cmd.numerator[31]}}, cmd.numerator[31:0]};
                d_eff  = {{(DATA_W-32){cmd.denominator[31]}}, cmd.denominator[31:0]};
                zero32 = (cmd.denominator[31:0] == 32'd0);
                ovf32  = (cmd.numerator[31:0] == 32'h8000_0000)
                         && (cmd.denominator[31:0] == 32'hFFFF_FFFF);
            end
            MODE_64_32, MODE_64_32_ALT:
            begin
                n_eff  = cmd.numerator;
                d_eff  = {{(DATA_W-32){cmd.denominator[31]}}, cmd.denominator[31:0]};
                zero32 = 1'b0;
                ovf32  = 1'b0;
            end
            MODE_64_64:
            begin
                n_eff  = cmd.numerator;
                d_eff  = cmd.denominator;
                zero32 = 1'b0;
                ovf32  = 1'b0;
            end
            default:
            begin
                n_eff  = cmd.numerator;
                d_eff  = cmd.denominator;
                zero32 = 1'b0;
                ovf32  = 1'b0;
            end
        endcase
    end

    // Magnitudes and flags. A zero divisor runs through the array and
    // yields an all-ones quotient magnitude and the dividend magnitude as remainder.
    always_comb
    begin
        n_neg               = n_eff[DATA_W-1];
        d_neg               = d_eff[DATA_W-1];
        ctrl_next.valid     = take;
        ctrl_next.q_neg     = n_neg ^ d_neg;
        ctrl_next.r_neg     = n_neg;
        ctrl_next.zero32    = zero32;
        ctrl_next.ovf32     = ovf32;
        ctrl_next.dz        = (cmd.denominator == '0);
        work_next.rem       = '0;
        work_next.quo       = n_neg ? (~n_eff + 1'b1) : n_eff;
        work_next.den       = d_neg ? (~d_eff + 1'b1) : d_eff;
    end

    // Stage registers; reset clears the valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            work_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            work_reg <= work_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign work_out = work_reg;

endmodule

### design/sd3m_step.sv
// ============================================================================
// sd3m_step - one restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor magnitude and registers the new remainder and quotient bit.
// ============================================================================
module sd3m_step (
    input  logic              clk,
    input  logic              rst_n,
    input  sd3m_pkg::ctrl_t   ctrl_in,
    input  sd3m_pkg::work_t   work_in,
    output sd3m_pkg::ctrl_t   ctrl_out,
    output sd3m_pkg::work_t   work_out
);
    import sd3m_pkg::*;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              fits;
    ctrl_t             ctrl_reg;
    work_t             work_reg;
    work_t             work_next;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        shifted       = {work_in.rem, work_in.quo[DATA_W-1]};
        diff          = {1'b0, shifted} - {2'b00, work_in.den};
        fits          = ~diff[DATA_W+1];
        work_next.rem = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        work_next.quo = {work_in.quo[DATA_W-2:0], fits};
        work_next.den = work_in.den;
    end

    // Stage registers; reset clears the valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            work_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            work_reg <= work_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign work_out = work_reg;

endmodule

### design/sd3m_post.sv
// ============================================================================
// sd3m_post - result sign fix-up stage
// Restores the signs of quotient and remainder, applies the 32/32 zero
// divisor and overflow quotients and registers the result transaction.
// ============================================================================
module sd3m_post (
    input  logic               clk,
    input  logic               rst_n,
    input  sd3m_pkg::ctrl_t    ctrl_in,
    input  sd3m_pkg::work_t    work_in,
    output logic               done,
    output sd3m_pkg::result_t  result
);
    import sd3m_pkg::*;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    // Sign restoration and the 32/32 zero divisor and overflow overrides.
    always_comb
    begin
        if (ctrl_in.zero32)
        begin
            result_next.quotient = ctrl_in.r_neg ? ZERO32_Q_NEG : ZERO32_Q_POS;
        end
        else if (ctrl_in.ovf32)
        begin
            result_next.quotient = OVF32_Q;
        end
        else
        begin
            result_next.quotient = ctrl_in.q_neg ? (~work_in.quo + 1'b1) : work_in.quo;
        end
        result_next.remainder      = ctrl_in.r_neg ? (~work_in.rem + 1'b1) : work_in.rem;
        result_next.divide_by_zero = ctrl_in.dz;
    end

    // Result strobe is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/signed_divider_three_modes.sv
// ============================================================================
// signed_divider_three_modes - pipelined signed divider, 32/32, 64/32, 64/64
// Truncating signed division with quotient, remainder and zero divisor flag.
// ============================================================================
// Throughput: one transaction per cycle; busy stays low.
// The pipeline is the 64-stage restoring array, one quotient bit per
// stage, plus one operand stage and one sign fix-up stage.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall; each result is shown for one cycle with done.
module signed_divider_three_modes (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sd3m_pkg::cmd_t     cmd,
    output logic               done,
    output sd3m_pkg::result_t  result
);
    import sd3m_pkg::*;

    ctrl_t stage_ctrl [0:DIV_STEPS];
    work_t stage_work [0:DIV_STEPS];

    // The pipeline never holds off a new transaction.
    assign busy = 1'b0;

    // Operand preparation.
    sd3m_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (start),
        .cmd      (cmd),
        .ctrl_out (stage_ctrl[0]),
        .work_out (stage_work[0])
    );

    // Restoring division array, one quotient bit per stage.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        sd3m_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (stage_ctrl[i]),
            .work_in  (stage_work[i]),
            .ctrl_out (stage_ctrl[i+1]),
            .work_out (stage_work[i+1])
        );
    end

    // Sign fix-up and result register.
    sd3m_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (stage_ctrl[DIV_STEPS]),
        .work_in (stage_work[DIV_STEPS]),
        .done    (done),
        .result  (result)
    );

endmodule

### design/sd3m_checker.sv
// ============================================================================
// sd3m_checker - port-level checks for the three-mode signed divider
// Watches the command and result ports for fixed latency and the
// zero divisor results.
// ============================================================================
module sd3m_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  sd3m_pkg::cmd_t     cmd,
    input  logic               done,
    input  sd3m_pkg::result_t  result
);
    import sd3m_pkg::*;

    // Every accepted transaction produces a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after an accepted transaction");

    // No result appears without a matching transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result strobe without an accepted transaction");

    // The zero flag follows the full denominator.
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY
            (result.divide_by_zero == $past(cmd.denominator == '0, LATENCY)))
        else $error("zero divisor flag does not match the denominator");

    // A 64/64 zero divisor with a non-negative dividend gives all ones.
    a_zero_q64: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == MODE_64_64) && (cmd.denominator == '0)
            && !cmd.numerator[DATA_W-1]) |-> ##LATENCY (result.quotient == '1))
        else $error("wrong quotient for a 64/64 zero divisor");

endmodule

bind signed_divider_three_modes sd3m_checker u_sd3m_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

### verif/signed_divider_three_modes_test.sv
// ============================================================================
// signed_divider_three_modes_test - self-checking bench for the signed divider
// Sends directed and random division commands in all width modes, including
// zero divisors and the most-negative-over-minus-one overflow. Each
// transaction's quotient, remainder and zero-divisor flag are predicted and
// then compared with what the divider returns. The run has phases with
// different amounts of sender idling.
// ============================================================================
module signed_divider_three_modes_test;

    import sd3m_pkg::*;

    localparam logic [63:0] SIGN64         = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_POS        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] OVF32_QUOTIENT = 64'h0000_0000_8000_0000;
    localparam int          RANDOM_ITEMS   = 1900;
    localparam int          WATCHDOG_LIMIT = 2000;

    // Predicts division results and checks them against the divider output.
    class division_scoreboard;
        result_t     expected_results[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Truncating signed division on 64-bit patterns; divisor is nonzero.
        static function void trunc_divide(input logic [63:0] n, input logic [63:0] d,
                                          output logic [63:0] q, output logic [63:0] r);
            logic [63:0] mag_n;
            logic [63:0] mag_d;
            logic [63:0] mag_q;
            logic [63:0] mag_r;
            mag_n = n[63] ? -n : n;
            mag_d = d[63] ? -d : d;
            mag_q = mag_n / mag_d;
            mag_r = mag_n % mag_d;
            q = (n[63] != d[63]) ? -mag_q : mag_q;
            r = n[63] ? -mag_r : mag_r;
        endfunction

        static function result_t predict_division(cmd_t c);
            logic [1:0]  mode;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] n;
            logic [63:0] d;
            logic [63:0] q;
            logic [63:0] r;
            result_t     res;
            num  = c.numerator;
            den  = c.denominator;
            mode = (c.opcode == MODE_64_32_ALT) ? MODE_64_32 : c.opcode;
            case (mode)
                MODE_32_32:
                begin
                    n = {{32{num[31]}}, num[31:0]};
                    d = {{32{den[31]}}, den[31:0]};
                    if (den[31:0] == 32'h0)
                    begin
                        q = n[63] ? ZERO32_Q_NEG : ZERO32_Q_POS;
                        r = n;
                    end
                    else if (num[31:0] == 32'h8000_0000 && den[31:0] == 32'hFFFF_FFFF)
                    begin
                        q = OVF32_QUOTIENT;
                        r = '0;
                    end
                    else
                    begin
                        trunc_divide(n, d, q, r);
                    end
                end
                MODE_64_32:
                begin
                    d = {{32{den[31]}}, den[31:0]};
                    if (den[31:0] == 32'h0)
                    begin
                        q = num[63] ? 64'd1 : ALL_ONES;
                        r = num;
                    end
                    else if (num == SIGN64 && den[31:0] == 32'hFFFF_FFFF)
                    begin
                        q = SIGN64;
                        r = '0;
                    end
                    else
                    begin
                        trunc_divide(num, d, q, r);
                    end
                end
                default:
                begin
                    if (den == '0)
                    begin
                        q = num[63] ? 64'd1 : ALL_ONES;
                        r = num;
                    end
                    else if (num == SIGN64 && den == ALL_ONES)
                    begin
                        q = SIGN64;
                        r = '0;
                    end
                    else
                    begin
                        trunc_divide(num, den, q, r);
                    end
                end
            endcase
            res.quotient       = q;
            res.remainder      = r;
            res.divide_by_zero = (den == '0);
            return res;
        endfunction

        function void note_command(cmd_t c);
            expected_results.push_back(predict_division(c));
        endfunction

        function void check_result(result_t actual);
            result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result q=%h r=%h dz=%b", $time,
                         actual.quotient, actual.remainder, actual.divide_by_zero);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (actual.quotient !== exp_res.quotient)
            begin
                $display("%0t: quotient mismatch: expected %h, actual %h", $time,
                         exp_res.quotient, actual.quotient);
                errors++;
            end
            if (actual.remainder !== exp_res.remainder)
            begin
                $display("%0t: remainder mismatch: expected %h, actual %h", $time,
                         exp_res.remainder, actual.remainder);
                errors++;
            end
            if (actual.divide_by_zero !== exp_res.divide_by_zero)
            begin
                $display("%0t: divide_by_zero mismatch: expected %b, actual %b", $time,
                         exp_res.divide_by_zero, actual.divide_by_zero);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               done;
    result_t            result;
    division_scoreboard sb;
    int unsigned        idle_cycles;

    signed_divider_three_modes DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Record accepted commands and check every result strobe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(cmd);
            if (done)
                sb.check_result(result);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("signed_divider_three_modes_test: errors");
            $finish;
        end
    end

    function automatic cmd_t division_cmd(logic [1:0] opcode, logic [63:0] num,
                                          logic [63:0] den);
        cmd_t c;
        c.opcode      = opcode;
        c.numerator   = num;
        c.denominator = den;
        return c;
    endfunction

    // Operand mix: full-range values, 32-bit values, small values, corner
    // values and values of random magnitude.
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            4: v = {{32{v[31]}}, v[31:0]};
            5: v = 64'($signed($urandom_range(40)) - 20);
            6:
            begin
                case ($urandom_range(7))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = ALL_ONES;
                    3: v = SIGN64;
                    4: v = MAX_POS;
                    5: v = 64'h0000_0000_8000_0000;
                    6: v = 64'h0000_0000_FFFF_FFFF;
                    default: v = {v[63:32], 32'h0};
                endcase
            end
            7: v = {{32{v[31]}}, v[31:0]} ^ {32'h0, $urandom};
            8: v = v >> $urandom_range(63);
            9: v = -(v >> $urandom_range(63));
            default: ;
        endcase
        return v;
    endfunction

    // Send one transaction, idling first with the given percentage.
    task automatic issue_division(cmd_t c, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic drain_divider();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Directed corner cases, then random phases with different idling.
    initial
    begin
        cmd_t directed[$];
        int   phase_idle[4];
        sb          = new();
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 32/32 mode: ordinary signs, ignored high words, zero divisor, overflow.
        directed.push_back(division_cmd(MODE_32_32, 64'd100, 64'd7));
        directed.push_back(division_cmd(MODE_32_32, 64'hDEAD_BEEF_FFFF_FF9C, 64'd7));
        directed.push_back(division_cmd(MODE_32_32, 64'h1234_0000_0000_0064,
                                        64'hABCD_0000_FFFF_FFF9));
        directed.push_back(division_cmd(MODE_32_32, 64'd55, 64'h0000_0001_0000_0000));
        directed.push_back(division_cmd(MODE_32_32, 64'h0000_0000_8000_0001, 64'd0));
        directed.push_back(division_cmd(MODE_32_32, 64'h5555_5555_8000_0000,
                                        64'hAAAA_AAAA_FFFF_FFFF));
        directed.push_back(division_cmd(MODE_32_32, MAX_POS, SIGN64 | 64'h8000_0000));
        // 64/32 mode and its alternate code.
        directed.push_back(division_cmd(MODE_64_32, 64'h7654_3210_FEDC_BA98,
                                        64'hFFFF_0000_0000_0013));
        directed.push_back(division_cmd(MODE_64_32, SIGN64 | 64'd5,
                                        64'h0000_0002_0000_0000));
        directed.push_back(division_cmd(MODE_64_32, 64'd9, 64'd0));
        directed.push_back(division_cmd(MODE_64_32, SIGN64, 64'h1234_5678_FFFF_FFFF));
        directed.push_back(division_cmd(MODE_64_32, SIGN64, 64'd1));
        directed.push_back(division_cmd(MODE_64_32_ALT, -64'd1000001, 64'hFFFF_FFFF_FFFF_FFFD));
        directed.push_back(division_cmd(MODE_64_32_ALT, SIGN64, ALL_ONES));
        directed.push_back(division_cmd(MODE_64_32_ALT, 64'd0, 64'h8000_0000_0000_0000));
        // 64/64 mode: extremes, overflow, zero divisor, low word zero.
        directed.push_back(division_cmd(MODE_64_64, MAX_POS, SIGN64));
        directed.push_back(division_cmd(MODE_64_64, SIGN64, ALL_ONES));
        directed.push_back(division_cmd(MODE_64_64, SIGN64 | 64'd3, 64'd0));
        directed.push_back(division_cmd(MODE_64_64, 64'd0, 64'd0));
        directed.push_back(division_cmd(MODE_64_64, ALL_ONES, 64'h0000_0003_0000_0000));
        directed.push_back(division_cmd(MODE_64_64, -64'd7, 64'd2));
        directed.push_back(division_cmd(MODE_64_64, MAX_POS, 64'd1));
        directed.push_back(division_cmd(MODE_64_64, SIGN64, MAX_POS));
        directed.push_back(division_cmd(MODE_64_64, SIGN64, SIGN64));
        foreach (directed[i])
            issue_division(directed[i], 0);
        drain_divider();

        // Random phases: back to back, heavy idling, light idling, back to back.
        phase_idle[0] = 0;
        phase_idle[1] = 72;
        phase_idle[2] = 7;
        phase_idle[3] = 0;
        foreach (phase_idle[p])
        begin
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                issue_division(division_cmd(2'($urandom_range(3)), random_operand(),
                                            random_operand()), phase_idle[p]);
            drain_divider();
        end

        if (sb.errors == 0)
            $display("signed_divider_three_modes_test: clean");
        else
            $display("signed_divider_three_modes_test: errors");
        $finish;
    end

endmodule
